@@ src/pmacc_pkg.sv @@
// types, constants and gain table shared by the pointer motion accelerator
package pmacc_pkg;

  localparam int unsigned TimeW   = 64;
  localparam int unsigned DeltaW  = 24;
  localparam int unsigned MagW    = 24;
  localparam int unsigned SpeedW  = 5;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned StepW   = 16;
  localparam int unsigned GainW   = 10;
  localparam int unsigned BoundW  = 16;
  localparam int unsigned MulAW   = 39;
  localparam int unsigned ProdW   = MulAW + SizeW;
  localparam int unsigned AccW    = ProdW - 16 + 1;
  localparam int unsigned QuoW    = 16;
  localparam int unsigned DvsW    = TimeW + QuoW;
  localparam int unsigned CntW    = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = SizeW;

  localparam int unsigned GainBins = 6;

  localparam logic [BoundW-1:0] BinBound [16] = '{
    16'd5, 16'd16, 16'd23, 16'd32, 16'd41, 16'd128, 16'd128, 16'd128,
    16'd128, 16'd128, 16'd128, 16'd128, 16'd128, 16'd128, 16'd128, 16'd128
  };
  localparam logic [GainW-1:0] BinGain [16] = '{
    10'd154, 10'd256, 10'd307, 10'd461, 10'd538, 10'd717, 10'd717, 10'd717,
    10'd717, 10'd717, 10'd717, 10'd717, 10'd717, 10'd717, 10'd717, 10'd717
  };

  localparam logic [SpeedW-1:0] SpeedReset  = 5'd10;
  localparam logic [SizeW-1:0]  WidthReset  = 13'd1920;
  localparam logic [SizeW-1:0]  HeightReset = 13'd1080;

  localparam logic StatusOk     = 1'b0;
  localparam logic StatusReject = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SPEED  = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_SPEED,
    ST_MUL_GAIN,
    ST_MUL_SIZE,
    ST_ROUND,
    ST_SAT,
    ST_DIV,
    ST_FIX,
    ST_CURSOR
  } state_e;

  typedef struct packed {
    logic [TimeW-1:0]         timestamp_us;
    logic signed [DeltaW-1:0] delta_x;
    logic signed [DeltaW-1:0] delta_y;
  } in_item_t;

  typedef struct packed {
    logic                    status;
    logic signed [StepW-1:0] step_x;
    logic signed [StepW-1:0] step_y;
    logic [SizeW-1:0]        cursor_x;
    logic [SizeW-1:0]        cursor_y;
  } out_item_t;

  // gain in q8 from ceil(mag / 256)
  function automatic logic [GainW-1:0] gain_for(input logic [MagW-1:0] mag);
    logic [MagW:0]    sum;
    logic [MagW-8:0]  n;
    logic [GainW-1:0] g;
    logic             hit;
    sum = {1'b0, mag} + (MagW+1)'(255);
    n   = sum[MagW:8];
    g   = BinGain[GainBins-1];
    hit = 1'b0;
    for (int i = 0; i < 16; i++) begin
      if (!hit && (i < GainBins) && (n <= (MagW-7)'(BinBound[i]))) begin
        g   = BinGain[i];
        hit = 1'b1;
      end
    end
    return g;
  endfunction

endpackage

@@ src/pointer_motion_accelerator_core.sv @@
// pointer motion accelerator: sequencer around one shared multiplier and divider step
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  in_data_i   (timestamp, dx, dy)
//   out      output     out_valid_o/out_stall_i out_data_o (status, steps, cursor)
//   cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
// a motion item runs, per axis, three multiply steps, a rounding and an overflow check,
// then 16 restoring divide steps and a fix-up step, before the cursor update
// a rejected item (time not advancing) skips the axis steps and goes straight to the cursor update
// rst_ni resets the sequencer, configuration, time and cursor state asynchronously
// in_stall_o is high while an item is in work; a stalled result waits in the output
// register and the next item is taken meanwhile
module pointer_motion_accelerator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pmacc_pkg::in_item_t                 in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pmacc_pkg::out_item_t                out_data_o,
  input  logic                                cfg_we_i,
  input  logic [pmacc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pmacc_pkg::CfgW-1:0]          cfg_data_i
);
  import pmacc_pkg::*;

  state_e                  state_q, state_d;
  logic [SpeedW-1:0]       speed_q, speed_d;
  logic [SizeW-1:0]        width_q, width_d;
  logic [SizeW-1:0]        height_q, height_d;
  logic [TimeW-1:0]        last_time_q, last_time_d;
  logic [SizeW-1:0]        pos_x_q, pos_x_d;
  logic [SizeW-1:0]        pos_y_q, pos_y_d;
  logic                    pos_valid_q, pos_valid_d;
  logic                    out_valid_q, out_valid_d;

  in_item_t                in_q, in_d;
  out_item_t               out_q, out_d;
  logic [TimeW-1:0]        dt_q, dt_d;
  logic                    reject_q, reject_d;
  logic                    axis_q, axis_d;
  logic [GainW-1:0]        gain_q, gain_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic [AccW-1:0]         rem_q, rem_d;
  logic [DvsW-1:0]         dvs_q, dvs_d;
  logic [QuoW-1:0]         quo_q, quo_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    sat_q, sat_d;
  logic signed [StepW-1:0] step_x_q, step_x_d;
  logic signed [StepW-1:0] step_y_q, step_y_d;

  logic signed [DeltaW-1:0] cur_delta;
  logic [DeltaW-1:0]        cur_delta_u;
  logic                     cur_neg;
  logic [MagW-1:0]          cur_mag;
  logic [SizeW-1:0]         cur_size;
  logic [MulAW-1:0]         mul_a;
  logic [SizeW-1:0]         mul_b;
  logic [ProdW-1:0]         mul_p;
  logic [ProdW:0]           rnd_sum;
  logic                     div_ge;
  logic [QuoW:0]            q_ceil;
  logic [QuoW:0]            q_lim;
  logic [QuoW:0]            q_sat;
  logic signed [StepW-1:0]  step_val;
  logic                     time_stale;
  logic                     out_free;
  logic                     in_fire;

  function automatic logic [SizeW-1:0] clamp_pos(input logic [SizeW-1:0] pos,
                                                 input logic signed [StepW-1:0] step,
                                                 input logic [SizeW-1:0] size);
    logic signed [SizeW+4:0] p;
    logic [SizeW-1:0]        hi;
    logic [SizeW-1:0]        r;
    p  = $signed({5'b0, pos}) + (SizeW+5)'(step);
    hi = (size == '0) ? '0 : size - 1'b1;
    if (p < 0) begin
      r = '0;
    end else if (p > $signed({5'b0, hi})) begin
      r = hi;
    end else begin
      r = p[SizeW-1:0];
    end
    return r;
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // current axis operands
  assign cur_delta   = axis_q ? in_q.delta_y : in_q.delta_x;
  assign cur_delta_u = cur_delta;
  assign cur_neg     = cur_delta[DeltaW-1];
  assign cur_mag     = cur_neg ? (~cur_delta_u + 1'b1) : cur_delta_u;
  assign cur_size    = axis_q ? height_q : width_q;

  // shared multiplier
  always_comb begin
    mul_a = prod_q[MulAW-1:0];
    mul_b = cur_size;
    case (state_q)
      ST_MUL_SPEED: begin
        mul_a = MulAW'(cur_mag);
        mul_b = SizeW'(speed_q);
      end
      ST_MUL_GAIN: begin
        mul_b = SizeW'(gain_q);
      end
      default: begin
        mul_b = cur_size;
      end
    endcase
  end
  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  assign rnd_sum    = {1'b0, prod_q} + (ProdW+1)'(16'hFFFF);
  assign div_ge     = ({(DvsW-AccW)'(0), rem_q} >= dvs_q);
  assign q_ceil     = {1'b0, quo_q} + (QuoW+1)'(rem_q != '0);
  assign q_lim      = cur_neg ? (QuoW+1)'(32768) : (QuoW+1)'(32767);
  assign q_sat      = (sat_q || (q_ceil > q_lim)) ? q_lim : q_ceil;
  assign step_val   = StepW'(cur_neg ? ((QuoW+1)'(0) - q_sat) : q_sat);
  assign time_stale = (in_q.timestamp_us <= last_time_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_fire) state_d = ST_PREP;
      ST_PREP:      state_d = time_stale ? ST_CURSOR : ST_MUL_SPEED;
      ST_MUL_SPEED: state_d = ST_MUL_GAIN;
      ST_MUL_GAIN:  state_d = ST_MUL_SIZE;
      ST_MUL_SIZE:  state_d = ST_ROUND;
      ST_ROUND:     state_d = ST_SAT;
      ST_SAT:       state_d = ST_DIV;
      ST_DIV:       if (cnt_q == CntW'(QuoW-1)) state_d = ST_FIX;
      ST_FIX:       state_d = axis_q ? ST_CURSOR : ST_MUL_SPEED;
      ST_CURSOR:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    speed_d     = speed_q;
    width_d     = width_q;
    height_d    = height_q;
    last_time_d = last_time_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    pos_valid_d = pos_valid_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_d        = in_q;
    out_d       = out_q;
    dt_d        = dt_q;
    reject_d    = reject_q;
    axis_d      = axis_q;
    gain_d      = gain_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    sat_d       = sat_q;
    step_x_d    = step_x_q;
    step_y_d    = step_y_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPEED:  speed_d  = cfg_data_i[SpeedW-1:0];
        CFG_WIDTH:  width_d  = cfg_data_i[SizeW-1:0];
        CFG_HEIGHT: height_d = cfg_data_i[SizeW-1:0];
        default:    speed_d  = speed_q;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) in_d = in_data_i;
      end
      ST_PREP: begin
        dt_d     = in_q.timestamp_us - last_time_q;
        reject_d = time_stale;
        axis_d   = 1'b0;
        step_x_d = '0;
        step_y_d = '0;
        if (!pos_valid_q) begin
          pos_x_d     = width_q >> 1;
          pos_y_d     = height_q >> 1;
          pos_valid_d = 1'b1;
        end
      end
      ST_MUL_SPEED: begin
        prod_d = mul_p;
        gain_d = gain_for(cur_mag);
      end
      ST_MUL_GAIN: begin
        prod_d = mul_p;
      end
      ST_MUL_SIZE: begin
        prod_d = mul_p;
      end
      ST_ROUND: begin
        rem_d = rnd_sum[ProdW:16];
      end
      ST_SAT: begin
        sat_d = ({(DvsW-AccW)'(0), rem_q} >= {dt_q, 16'b0});
        dvs_d = {1'b0, dt_q, 15'b0};
        quo_d = '0;
        cnt_d = '0;
      end
      ST_DIV: begin
        if (div_ge) rem_d = rem_q - dvs_q[AccW-1:0];
        quo_d = {quo_q[QuoW-2:0], div_ge};
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q + 1'b1;
      end
      ST_FIX: begin
        if (axis_q) begin
          step_y_d = step_val;
        end else begin
          step_x_d = step_val;
          axis_d   = 1'b1;
        end
      end
      ST_CURSOR: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (reject_q) begin
            out_d.status   = StatusReject;
            out_d.step_x   = '0;
            out_d.step_y   = '0;
            out_d.cursor_x = pos_x_q;
            out_d.cursor_y = pos_y_q;
          end else begin
            pos_x_d        = clamp_pos(pos_x_q, step_x_q, width_q);
            pos_y_d        = clamp_pos(pos_y_q, step_y_q, height_q);
            last_time_d    = in_q.timestamp_us;
            out_d.status   = StatusOk;
            out_d.step_x   = step_x_q;
            out_d.step_y   = step_y_q;
            out_d.cursor_x = pos_x_d;
            out_d.cursor_y = pos_y_d;
          end
        end
      end
      default: begin
        axis_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      speed_q     <= SpeedReset;
      width_q     <= WidthReset;
      height_q    <= HeightReset;
      last_time_q <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      pos_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      speed_q     <= speed_d;
      width_q     <= width_d;
      height_q    <= height_d;
      last_time_q <= last_time_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      pos_valid_q <= pos_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q     <= in_d;
    out_q    <= out_d;
    dt_q     <= dt_d;
    reject_q <= reject_d;
    axis_q   <= axis_d;
    gain_q   <= gain_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    sat_q    <= sat_d;
    step_x_q <= step_x_d;
    step_y_q <= step_y_d;
  end

endmodule

@@ src/pmacc_checker.sv @@
// port-level checks for the pointer motion accelerator and their binding
module pmacc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input pmacc_pkg::out_item_t out_data_o
);
  import pmacc_pkg::*;

  // a result waiting on stall keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // an accepted item blocks the input for at least the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held off after acceptance");

  // a rejected item moves nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == StatusReject) |->
      (out_data_o.step_x == '0) && (out_data_o.step_y == '0))
    else $error("rejected item carries a step");

  // handshake outputs are always known
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_stall_o, out_valid_o}))
    else $error("handshake output unknown");

endmodule

bind pointer_motion_accelerator_core pmacc_checker u_pmacc_checker (.*);

@@ sim/pointer_motion_accelerator_checker.sv @@
// checker for the pointer motion accelerator: predicts each result and compares it
module pointer_motion_accelerator_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  pmacc_pkg::in_item_t           in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  pmacc_pkg::out_item_t          out_data_i,
  input  logic                          cfg_we_i,
  input  logic [pmacc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pmacc_pkg::CfgW-1:0]    cfg_data_i,
  output int                            n_pending_o,
  output int                            n_errors_o
);
  import pmacc_pkg::*;

  logic [SpeedW-1:0] cfg_speed;
  logic [SizeW-1:0]  cfg_width;
  logic [SizeW-1:0]  cfg_height;
  logic [TimeW-1:0]  last_time;
  logic [SizeW-1:0]  pos_x;
  logic [SizeW-1:0]  pos_y;
  logic              pos_valid;

  out_item_t expected_moves [$];
  int        mismatch_count;

  function automatic logic [GainW-1:0] gain_q8(input logic [MagW-1:0] mag);
    logic [MagW:0] counts;
    counts = ({1'b0, mag} + (MagW+1)'(255)) >> 8;
    if (counts <= 5) return 10'd154;
    if (counts <= 16) return 10'd256;
    if (counts <= 23) return 10'd307;
    if (counts <= 32) return 10'd461;
    if (counts <= 41) return 10'd538;
    return 10'd717;
  endfunction

  function automatic logic signed [StepW-1:0] axis_step(input logic signed [DeltaW-1:0] d,
                                                         input logic [SizeW-1:0] size,
                                                         input logic [TimeW-1:0] dt);
    logic             neg;
    logic [MagW-1:0]  mag;
    logic [63:0]      num;
    logic [63:0]      scaled;
    logic [63:0]      q;
    neg    = d[DeltaW-1];
    mag    = neg ? MagW'(-d) : MagW'(d);
    num    = 64'(mag) * 64'(cfg_speed) * 64'(gain_q8(mag)) * 64'(size);
    scaled = (num + 64'd65535) >> 16;
    q      = scaled / dt;
    if ((scaled % dt) != 0) q = q + 64'd1;
    if (neg) begin
      if (q > 64'd32768) q = 64'd32768;
      return StepW'(64'd0 - q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return StepW'(q);
  endfunction

  function automatic logic [SizeW-1:0] clamp_axis(input logic [SizeW-1:0] pos,
                                                  input logic signed [StepW-1:0] step,
                                                  input logic [SizeW-1:0] size);
    logic signed [31:0] p;
    logic signed [31:0] hi;
    p  = $signed({19'd0, pos}) + {{16{step[StepW-1]}}, step};
    hi = (size > 0) ? $signed({19'd0, size}) - 32'sd1 : 32'sd0;
    if (p < 0) p = 0;
    if (p > hi) p = hi;
    return p[SizeW-1:0];
  endfunction

  function automatic out_item_t predict_motion(input in_item_t m);
    out_item_t r;
    logic [TimeW-1:0] dt;
    if (!pos_valid) begin
      pos_x     = cfg_width >> 1;
      pos_y     = cfg_height >> 1;
      pos_valid = 1'b1;
    end
    r.status = StatusOk;
    r.step_x = '0;
    r.step_y = '0;
    if (m.timestamp_us <= last_time) begin
      r.status = StatusReject;
    end else begin
      dt        = m.timestamp_us - last_time;
      r.step_x  = axis_step(m.delta_x, cfg_width, dt);
      r.step_y  = axis_step(m.delta_y, cfg_height, dt);
      pos_x     = clamp_axis(pos_x, r.step_x, cfg_width);
      pos_y     = clamp_axis(pos_y, r.step_y, cfg_height);
      last_time = m.timestamp_us;
    end
    r.cursor_x = pos_x;
    r.cursor_y = pos_y;
    return r;
  endfunction

  task automatic note_field(input string what, input logic [63:0] exp_v,
                            input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      if (mismatch_count < 10) begin
        $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
      end
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      cfg_speed      = SpeedReset;
      cfg_width      = WidthReset;
      cfg_height     = HeightReset;
      last_time      = '0;
      pos_x          = '0;
      pos_y          = '0;
      pos_valid      = 1'b0;
      mismatch_count = 0;
      expected_moves.delete();
      n_pending_o   <= 0;
      n_errors_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_SPEED:  cfg_speed  = cfg_data_i[SpeedW-1:0];
          CFG_WIDTH:  cfg_width  = cfg_data_i[SizeW-1:0];
          CFG_HEIGHT: cfg_height = cfg_data_i[SizeW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_moves.push_back(predict_motion(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_moves.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result %0h", out_data_i);
          mismatch_count++;
        end else begin
          want = expected_moves.pop_front();
          note_field("status", 64'(want.status), 64'(out_data_i.status));
          note_field("step_x", 64'(want.step_x), 64'(out_data_i.step_x));
          note_field("step_y", 64'(want.step_y), 64'(out_data_i.step_y));
          note_field("cursor_x", 64'(want.cursor_x), 64'(out_data_i.cursor_x));
          note_field("cursor_y", 64'(want.cursor_y), 64'(out_data_i.cursor_y));
        end
      end
      n_pending_o <= expected_moves.size();
      n_errors_o  <= mismatch_count;
    end
  end

endmodule

@@ sim/pointer_motion_accelerator_core_tb.sv @@
// testbench top for the pointer motion accelerator: stimulus, config phases and verdict
module pointer_motion_accelerator_core_tb;
  import pmacc_pkg::*;

  localparam int CycleLimit    = 1000000;
  localparam int PhaseCount    = 8;
  localparam int ItemsPerPhase = 217;

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               cfg_we   = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx  = '0;
  logic [CfgW-1:0]    cfg_data = '0;
  int                 n_pending;
  int                 n_errors;

  logic [TimeW-1:0] last_ok = '0;
  int               stall_run = 0;
  int               cycle_count = 0;

  int speed_plan  [PhaseCount] = '{-1, 1, 20, 0, 31, -1, 5, -1};
  int width_plan  [PhaseCount] = '{-1, 1, 8191, 1920, 0, -1, 8191, -1};
  int height_plan [PhaseCount] = '{-1, 1, 8191, 1080, 8191, -1, 1, -1};
  int bin_edges   [6]          = '{5, 16, 23, 32, 41, 128};

  pointer_motion_accelerator_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  pointer_motion_accelerator_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .n_pending_o (n_pending),
    .n_errors_o  (n_errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      if ($urandom_range(0, 99) < 35) begin
        out_stall <= 1'b1;
        stall_run <= idle_len();
      end else begin
        out_stall <= 1'b0;
        stall_run <= ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 8);
      end
    end else begin
      stall_run <= stall_run - 1;
    end
  end

  function automatic in_item_t motion(input logic [TimeW-1:0] t, input int dx, input int dy);
    in_item_t m;
    m.timestamp_us = t;
    m.delta_x      = DeltaW'(dx);
    m.delta_y      = DeltaW'(dy);
    return m;
  endfunction

  function automatic logic signed [DeltaW-1:0] random_delta();
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r >= 85) return DeltaW'($urandom);
    mag = (r < 25) ? $urandom_range(0, 1023) : $urandom_range(0, 33000);
    return $urandom_range(0, 1) ? DeltaW'(-mag) : DeltaW'(mag);
  endfunction

  function automatic in_item_t random_motion();
    in_item_t m;
    int       r;
    int       dt;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      r  = $urandom_range(0, 99);
      dt = (r < 10) ? $urandom_range(1, 20)
         : (r < 80) ? $urandom_range(21, 2000) : $urandom_range(2001, 1000000);
      m.timestamp_us = last_ok + TimeW'(dt);
    end else if ($urandom_range(0, 1)) begin
      m.timestamp_us = (last_ok >= 64) ? last_ok - TimeW'($urandom_range(0, 63)) : last_ok;
    end else begin
      m.timestamp_us = {$urandom, $urandom};
    end
    m.delta_x = random_delta();
    m.delta_y = random_delta();
    return m;
  endfunction

  task automatic send_motion(input in_item_t m);
    int gap;
    gap = ($urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (m.timestamp_us > last_ok) last_ok = m.timestamp_us;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (n_pending != 0) @(posedge clk_i);
  endtask

  task automatic configure(input int speed, input int width, input int height);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SPEED;
    cfg_data <= CfgW'(speed);
    @(posedge clk_i);
    cfg_idx  <= CFG_WIDTH;
    cfg_data <= CfgW'(width);
    @(posedge clk_i);
    cfg_idx  <= CFG_HEIGHT;
    cfg_data <= CfgW'(height);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first item sets the centre even though time has not advanced
    send_motion(motion(64'd0, 0, 0));
    send_motion(motion(64'd1000, 256, -256));
    send_motion(motion(64'd1000, 512, 512));
    send_motion(motion(64'd999, -1, 1));
    send_motion(motion(64'd1001, 8388607, -8388608));
    send_motion(motion(64'd1002, -8388608, 8388607));
    send_motion(motion(64'd1003, 0, 0));
    for (int i = 0; i < 6; i++) begin
      send_motion(motion(64'd1003 + 64'(100000 * (i + 1)), bin_edges[i] * 256,
                         -(bin_edges[i] * 256 + 1)));
    end
    send_motion(motion(64'd1 << 40, 1, -1));
    send_motion(motion((64'd1 << 40) + 64'd1, -1, 1));

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      configure((speed_plan[p] < 0) ? $urandom_range(1, 20) : speed_plan[p],
                (width_plan[p] < 0) ? $urandom_range(1, 8191) : width_plan[p],
                (height_plan[p] < 0) ? $urandom_range(1, 8191) : height_plan[p]);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        send_motion(random_motion());
      end
    end

    drain_results();
    repeat (60) @(posedge clk_i);
    if (n_errors == 0 && n_pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pmacc_pkg.sv
src/pointer_motion_accelerator_core.sv
src/pmacc_checker.sv
sim/pointer_motion_accelerator_checker.sv
sim/pointer_motion_accelerator_core_tb.sv
